/* sv/software_timer_bank_core_macros.svh */
// Assertion macros for the timer bank core.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SOFTWARE_TIMER_BANK_CORE_MACROS_SVH
`define SOFTWARE_TIMER_BANK_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, checked outside reset.
`define STB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

/* sv/stb_pkg.sv */
// Shared types and constants for the timer bank core.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package stb_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int ID_W       = 31;
  localparam int TIME_W     = 32;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 3;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED     = 3'd0,
    KIND_CREATED   = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_DELETED   = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DEL,
    ST_DEL_MV,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic              periodic;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
  } slot_t;

  localparam int ENTRY_W = $bits(slot_t);

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] ident;
  } rsp_t;

endpackage

/* sv/stb_if.sv */
// Request and result channel interfaces for the timer bank core.
// Depends on stb_pkg for field widths.
interface stb_req_if;
  logic                        valid;
  logic                        ready;
  logic [stb_pkg::MODE_W-1:0]  mode;
  logic [stb_pkg::TIME_W-1:0]  tick_step;
  logic                        is_periodic;
  logic [stb_pkg::TIME_W-1:0]  interval;
  logic [stb_pkg::ID_W-1:0]    target_id;

  modport source (output valid, mode, tick_step, is_periodic, interval, target_id,
                  input ready);
  modport sink   (input valid, mode, tick_step, is_periodic, interval, target_id,
                  output ready);
endinterface

interface stb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [stb_pkg::KIND_W-1:0]  kind;
  logic [stb_pkg::ID_W-1:0]    tmr_id;
  logic                        last;

  modport source (output valid, kind, tmr_id, last, input ready);
  modport sink   (input valid, kind, tmr_id, last, output ready);
endinterface

/* sv/stb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/software_timer_bank_core.sv */
// Timer bank top level: request sequencer around one slot RAM.
// Depends on stb_pkg, stb_if.sv, stb_ram and the assertion macro header.
//
//   channel  | role   | word
//   ---------+--------+-----------------------------------------------
//   in_req   | sink   | mode, tick_step, is_periodic, interval, target_id
//   out_rsp  | source | kind, tmr_id, last
//
// A create that finds room writes its slot on acceptance; a tick and a delete
// walk the live slots, one RAM read per cycle unless the result port stalls it.
// Reset (synchronous, active low) empties the bank and sets the next id to 1;
// the slot RAM is not cleared, as only live slots are ever read.
// A stalled result port holds the walk only when a second result must leave.
`include "software_timer_bank_core_macros.svh"

module software_timer_bank_core (
  input  logic       clk,
  input  logic       rst_n,
  stb_req_if.sink    in_req,
  stb_rsp_if.source  out_rsp
);

  stb_pkg::state_t                  state_r, state_nxt;
  logic [stb_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [stb_pkg::SLOT_W-1:0]       idx_r, idx_nxt;
  logic [stb_pkg::SLOT_W-1:0]       src_r;
  logic [stb_pkg::ID_W-1:0]         next_id_r, next_id_nxt;
  logic [stb_pkg::TIME_W-1:0]       step_r, step_nxt;
  logic [stb_pkg::ID_W-1:0]         target_r, target_nxt;
  logic                             pend_v_r, pend_v_nxt;
  stb_pkg::rsp_t                    pend_r, pend_nxt;
  logic                             out_v_r, out_v_nxt;
  stb_pkg::rsp_t                    out_r, out_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             ram_we;
  logic [stb_pkg::SLOT_W-1:0]       ram_waddr, ram_raddr;
  logic [stb_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;
  stb_pkg::slot_t                   cur, new_slot;

  logic                             accept, out_free, fire, stall;
  logic [stb_pkg::TIME_W:0]         sum;
  logic [stb_pkg::TIME_W-1:0]       esat;
  logic [stb_pkg::CNT_W-1:0]        tail, idx_ext, idx_inc;
  logic [stb_pkg::SLOT_W-1:0]       tail_slot, cnt_slot;
  logic [stb_pkg::ID_W-1:0]         id_inc;

  stb_ram #(
    .WIDTH (stb_pkg::ENTRY_W),
    .DEPTH (stb_pkg::SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur       = stb_pkg::slot_t'(ram_rdata);
  assign sum       = {1'b0, cur.elapsed} + {1'b0, step_r};
  assign esat      = sum[stb_pkg::TIME_W] ? {stb_pkg::TIME_W{1'b1}}
                                          : sum[stb_pkg::TIME_W-1:0];
  assign fire      = esat > cur.limit;
  assign tail      = cnt_r - 1'b1;
  assign tail_slot = tail[stb_pkg::SLOT_W-1:0];
  assign cnt_slot  = cnt_r[stb_pkg::SLOT_W-1:0];
  assign idx_ext   = stb_pkg::CNT_W'(idx_r);
  assign idx_inc   = idx_ext + 1'b1;
  assign id_inc    = next_id_r + 1'b1;

  assign out_free  = !out_v_r || out_rsp.ready;
  assign in_req.ready = (state_r == stb_pkg::ST_IDLE);
  assign accept    = in_req.valid && in_req.ready;
  // A second firing needs the held result to move out first.
  assign stall     = (state_r == stb_pkg::ST_TICK) && fire && pend_v_r && !out_free;

  assign out_rsp.valid  = out_v_r;
  assign out_rsp.kind   = out_r.kind;
  assign out_rsp.tmr_id = out_r.ident;
  assign out_rsp.last   = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    next_id_nxt  = next_id_r;
    step_nxt     = step_r;
    target_nxt   = target_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_rsp.ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_raddr    = src_r;
    new_slot     = cur;
    ram_wdata    = new_slot;

    case (state_r)
      stb_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req.mode)
            stb_pkg::MODE_TICK: begin
              step_nxt = in_req.tick_step;
              if (cnt_r != '0) begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = stb_pkg::ST_TICK;
              end
            end
            stb_pkg::MODE_CREATE: begin
              pend_v_nxt = 1'b1;
              state_nxt  = stb_pkg::ST_FLUSH;
              if (cnt_r < stb_pkg::CNT_W'(stb_pkg::SLOT_COUNT)) begin
                new_slot.ident    = next_id_r;
                new_slot.periodic = in_req.is_periodic;
                new_slot.elapsed  = '0;
                new_slot.limit    = in_req.interval;
                ram_we      = 1'b1;
                ram_waddr   = cnt_slot;
                ram_wdata   = new_slot;
                cnt_nxt     = cnt_r + 1'b1;
                pend_nxt    = '{kind: stb_pkg::KIND_CREATED, ident: next_id_r};
                next_id_nxt = (id_inc == '0) ? stb_pkg::ID_W'(1) : id_inc;
              end else begin
                pend_nxt = '{kind: stb_pkg::KIND_FULL, ident: '0};
              end
            end
            stb_pkg::MODE_DELETE: begin
              target_nxt = in_req.target_id;
              if (cnt_r != '0) begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = stb_pkg::ST_DEL;
              end else begin
                pend_v_nxt = 1'b1;
                pend_nxt   = '{kind: stb_pkg::KIND_NOT_FOUND, ident: in_req.target_id};
                state_nxt  = stb_pkg::ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      stb_pkg::ST_TICK: begin
        if (!stall) begin
          if (fire) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{kind: stb_pkg::KIND_FIRED, ident: cur.ident};
          end
          if (fire && !cur.periodic) begin
            // The last slot is read next and evaluated in this slot's place.
            cnt_nxt = tail;
            if (idx_ext < tail) begin
              ram_raddr = tail_slot;
            end else begin
              state_nxt = stb_pkg::ST_FLUSH;
            end
          end else begin
            new_slot.elapsed = fire ? '0 : esat;
            ram_we    = 1'b1;
            ram_wdata = new_slot;
            if (idx_inc < cnt_r) begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end else begin
              state_nxt = stb_pkg::ST_FLUSH;
            end
          end
        end
      end

      stb_pkg::ST_DEL: begin
        if (cur.ident == target_r) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = '{kind: stb_pkg::KIND_DELETED, ident: target_r};
          cnt_nxt    = tail;
          if (idx_ext != tail) begin
            ram_raddr = tail_slot;
            state_nxt = stb_pkg::ST_DEL_MV;
          end else begin
            state_nxt = stb_pkg::ST_FLUSH;
          end
        end else if (idx_inc < cnt_r) begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end else begin
          pend_v_nxt = 1'b1;
          pend_nxt   = '{kind: stb_pkg::KIND_NOT_FOUND, ident: target_r};
          state_nxt  = stb_pkg::ST_FLUSH;
        end
      end

      stb_pkg::ST_DEL_MV: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_nxt = stb_pkg::ST_FLUSH;
      end

      stb_pkg::ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = stb_pkg::ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = stb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= stb_pkg::ST_IDLE;
      cnt_r     <= '0;
      next_id_r <= stb_pkg::ID_W'(1);
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      next_id_r <= next_id_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    src_r      <= ram_raddr;
    step_r     <= step_nxt;
    target_r   <= target_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  `STB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= stb_pkg::CNT_W'(stb_pkg::SLOT_COUNT))
  `STB_ASSERT_NOW(a_id_nonzero, 1'b1, next_id_r != '0)
  `STB_ASSERT_NOW(a_idle_no_pend, state_r == stb_pkg::ST_IDLE, !pend_v_r)
  `STB_ASSERT_NEXT(a_once_removed,
                   state_r == stb_pkg::ST_TICK && fire && !cur.periodic && !stall,
                   cnt_r == $past(cnt_r) - 1'b1)
  `STB_ASSERT_NOW(a_walk_in_range,
                  state_r == stb_pkg::ST_TICK || state_r == stb_pkg::ST_DEL,
                  idx_ext < cnt_r)

endmodule
